[rtl/core/atot_pkg.sv]
`timescale 1ns / 1ps
package atot_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int LANE_BITS      = 16;
    localparam int WORD_BITS      = 48;
    localparam int NUM_AXES       = 13;
endpackage

[rtl/core/atot_if.sv]
`timescale 1ns / 1ps
interface atot_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] box_min;
    logic [47:0] box_max;
    logic [47:0] vertex_a;
    logic [47:0] vertex_b;
    logic [47:0] vertex_c;
    modport source (output valid, box_min, box_max, vertex_a, vertex_b, vertex_c,
                    input ready);
    modport sink (input valid, box_min, box_max, vertex_a, vertex_b, vertex_c,
                  output ready);
endinterface

interface atot_out_if;
    logic valid;
    logic ready;
    logic overlaps;
    modport source (output valid, overlaps, input ready);
    modport sink (input valid, overlaps, output ready);
endinterface

[rtl/core/atot_axis_test.sv]
`timescale 1ns / 1ps
// One separating-axis test, two register stages: products, then sums and compares.
// Axis components are AW bits; points are CW bits. Stall via en.
module atot_axis_test #(
    parameter int CW = 16,
    parameter int AW = 18
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] ax [3],
    input  logic signed [CW-1:0] lo [3],
    input  logic signed [CW-1:0] hi [3],
    input  logic signed [CW-1:0] va [3],
    input  logic signed [CW-1:0] vb [3],
    input  logic signed [CW-1:0] vc [3],
    output logic                 sep
);
    localparam int PW = AW + CW;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic signed [PW-1:0] pc_reg [3];
    logic signed [PW-1:0] pmin_reg [3];
    logic signed [PW-1:0] pmax_reg [3];
    logic signed [SW-1:0] da, db, dc, bmin, bmax, tmin, tmax;
    logic                 sep_reg;

    // stage 1: per-component products, box extremes per component
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [PW-1:0] p, q;
                p = PW'(ax[k]) * PW'(lo[k]);
                q = PW'(ax[k]) * PW'(hi[k]);
                pa_reg[k]   <= PW'(ax[k]) * PW'(va[k]);
                pb_reg[k]   <= PW'(ax[k]) * PW'(vb[k]);
                pc_reg[k]   <= PW'(ax[k]) * PW'(vc[k]);
                pmin_reg[k] <= (p < q) ? p : q;
                pmax_reg[k] <= (p < q) ? q : p;
            end
        end
    end

    // stage 2: dot sums, interval compare
    always_comb
    begin
        da   = SW'(pa_reg[0]) + SW'(pa_reg[1]) + SW'(pa_reg[2]);
        db   = SW'(pb_reg[0]) + SW'(pb_reg[1]) + SW'(pb_reg[2]);
        dc   = SW'(pc_reg[0]) + SW'(pc_reg[1]) + SW'(pc_reg[2]);
        bmin = SW'(pmin_reg[0]) + SW'(pmin_reg[1]) + SW'(pmin_reg[2]);
        bmax = SW'(pmax_reg[0]) + SW'(pmax_reg[1]) + SW'(pmax_reg[2]);
        tmin = (da < db) ? da : db;
        tmin = (dc < tmin) ? dc : tmin;
        tmax = (da > db) ? da : db;
        tmax = (dc > tmax) ? dc : tmax;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sep_reg <= (bmax < tmin) || (tmax < bmin);
        end
    end

    assign sep = sep_reg;
endmodule

[rtl/core/atot_axis_gen.sv]
`timescale 1ns / 1ps
// Axis generation stage: edges, edge cross axes, and normal (two stages).
// Outputs are delayed copies of the points aligned with the axes.
module atot_axis_gen #(
    parameter int CW = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [CW-1:0]     va [3],
    input  logic signed [CW-1:0]     vb [3],
    input  logic signed [CW-1:0]     vc [3],
    input  logic signed [CW-1:0]     lo [3],
    input  logic signed [CW-1:0]     hi [3],
    output logic signed [2*CW+2:0]   axes [13][3],
    output logic signed [CW-1:0]     va_o [3],
    output logic signed [CW-1:0]     vb_o [3],
    output logic signed [CW-1:0]     vc_o [3],
    output logic signed [CW-1:0]     lo_o [3],
    output logic signed [CW-1:0]     hi_o [3]
);
    localparam int EW = CW + 1;
    localparam int XW = 2 * CW + 3;

    logic signed [EW-1:0] e_reg [3][3];   // e0=a-b, e1=b-c, e2=c-a
    logic signed [EW-1:0] f_reg [3];      // b-a for normal
    logic signed [EW-1:0] g_reg [3];      // c-a for normal
    logic signed [CW-1:0] p1_reg [5][3];
    logic signed [XW-1:0] axes_reg [13][3];
    logic signed [CW-1:0] p2_reg [5][3];

    // stage 1: differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_reg[0][k] <= EW'(va[k]) - EW'(vb[k]);
                e_reg[1][k] <= EW'(vb[k]) - EW'(vc[k]);
                e_reg[2][k] <= EW'(vc[k]) - EW'(va[k]);
                f_reg[k]    <= EW'(vb[k]) - EW'(va[k]);
                g_reg[k]    <= EW'(vc[k]) - EW'(va[k]);
                p1_reg[0][k] <= va[k];
                p1_reg[1][k] <= vb[k];
                p1_reg[2][k] <= vc[k];
                p1_reg[3][k] <= lo[k];
                p1_reg[4][k] <= hi[k];
            end
        end
    end

    // stage 2: axes; normal uses 17x17 products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    axes_reg[j][k] <= (j == k) ? XW'(1) : XW'(0);
                end
            end
            axes_reg[3][0] <= XW'(f_reg[1]) * XW'(g_reg[2]) - XW'(f_reg[2]) * XW'(g_reg[1]);
            axes_reg[3][1] <= XW'(f_reg[2]) * XW'(g_reg[0]) - XW'(f_reg[0]) * XW'(g_reg[2]);
            axes_reg[3][2] <= XW'(f_reg[0]) * XW'(g_reg[1]) - XW'(f_reg[1]) * XW'(g_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                // x cross e = (0, -ez, ey)
                axes_reg[4+3*i][0] <= XW'(0);
                axes_reg[4+3*i][1] <= -XW'(e_reg[i][2]);
                axes_reg[4+3*i][2] <= XW'(e_reg[i][1]);
                // y cross e = (ez, 0, -ex)
                axes_reg[5+3*i][0] <= XW'(e_reg[i][2]);
                axes_reg[5+3*i][1] <= XW'(0);
                axes_reg[5+3*i][2] <= -XW'(e_reg[i][0]);
                // z cross e = (-ey, ex, 0)
                axes_reg[6+3*i][0] <= -XW'(e_reg[i][1]);
                axes_reg[6+3*i][1] <= XW'(e_reg[i][0]);
                axes_reg[6+3*i][2] <= XW'(0);
            end
            p2_reg <= p1_reg;
        end
    end

    assign axes = axes_reg;
    assign va_o = p2_reg[0];
    assign vb_o = p2_reg[1];
    assign vc_o = p2_reg[2];
    assign lo_o = p2_reg[3];
    assign hi_o = p2_reg[4];
endmodule

[rtl/core/aabb_triangle_overlap_test.sv]
`timescale 1ns / 1ps
// Box-triangle overlap test by separating axes. Fully pipelined: one test is
// accepted every cycle while the output is not stalled. There is one register
// stage each for unpack, edge differences, axis products, projection products
// and interval compare, then the 13 axis flags are combined into the output
// register. When a result waits at the output and the sink holds ready low, the
// whole pipeline stalls; no beat is dropped or duplicated. Touching counts as
// overlap.
module aabb_triangle_overlap_test #(
    parameter int COORD_BITS = atot_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    atot_in_if.sink    in_ch,
    atot_out_if.source out_ch
);
    import atot_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int AW    = 2 * CW + 3;
    localparam int DEPTH = 6;

    logic                 en;
    logic [DEPTH-1:0]     vld_reg;
    logic signed [CW-1:0] lo_reg [3], hi_reg [3], va_reg [3], vb_reg [3], vc_reg [3];
    logic signed [AW-1:0] axes [NUM_AXES][3];
    logic signed [CW-1:0] va2 [3], vb2 [3], vc2 [3], lo2 [3], hi2 [3];
    logic [NUM_AXES-1:0]  sep;
    logic                 ovl_reg;

    // pipeline advances unless a result is stuck at the output
    assign en          = !vld_reg[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
        end
    end

    // unpack lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= in_ch.box_min[k*LANE_BITS +: CW];
                hi_reg[k] <= in_ch.box_max[k*LANE_BITS +: CW];
                va_reg[k] <= in_ch.vertex_a[k*LANE_BITS +: CW];
                vb_reg[k] <= in_ch.vertex_b[k*LANE_BITS +: CW];
                vc_reg[k] <= in_ch.vertex_c[k*LANE_BITS +: CW];
            end
        end
    end

    atot_axis_gen #(.CW(CW)) u_gen (
        .clk(clk), .en(en),
        .va(va_reg), .vb(vb_reg), .vc(vc_reg), .lo(lo_reg), .hi(hi_reg),
        .axes(axes),
        .va_o(va2), .vb_o(vb2), .vc_o(vc2), .lo_o(lo2), .hi_o(hi2)
    );

    for (genvar n = 0; n < NUM_AXES; n++)
    begin : g_axis
        atot_axis_test #(.CW(CW), .AW(AW)) u_test (
            .clk(clk), .en(en), .ax(axes[n]),
            .lo(lo2), .hi(hi2), .va(va2), .vb(vb2), .vc(vc2),
            .sep(sep[n])
        );
    end

    // combine flags
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovl_reg <= ~|sep;
        end
    end

    assign out_ch.valid    = vld_reg[DEPTH-1];
    assign out_ch.overlaps = ovl_reg;
endmodule

[rtl/core/atot_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the overlap tester.
module atot_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic overlaps
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(overlaps))
        else $error("result changed while stalled");
    // input taken whenever output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    // stall propagates to input
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted during output stall");
endmodule

bind aabb_triangle_overlap_test atot_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .overlaps(out_ch.overlaps)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import atot_pkg::*;

    localparam int CB         = COORD_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef longint vec_t [3];

    logic clk;
    logic rst_n;

    atot_in_if  in_ch ();
    atot_out_if out_ch ();

    aabb_triangle_overlap_test #(.COORD_BITS(CB)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    bit expected_overlaps [$];
    int fail_count;
    int idle_cycles;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Coordinate helpers
    function automatic longint coord(logic [WORD_BITS-1:0] word, int idx);
        longint v;
        v = longint'(word[LANE_BITS*idx +: LANE_BITS]) & ((64'sd1 <<< CB) - 1);
        if (v[CB-1])
            v = v - (64'sd1 <<< CB);
        return v;
    endfunction

    function automatic vec_t unpack_word(logic [WORD_BITS-1:0] word);
        vec_t r;
        for (int i = 0; i < 3; i++)
            r[i] = coord(word, i);
        return r;
    endfunction

    function automatic vec_t cross3(vec_t a, vec_t b);
        vec_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    function automatic longint dot3(vec_t a, vec_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Strictly disjoint projections on this axis
    function automatic bit axis_separates(vec_t ax, vec_t t0, vec_t t1, vec_t t2,
                                          vec_t lo, vec_t hi);
        longint d [3];
        longint tmin, tmax, bmin, bmax, p, q;
        d[0] = dot3(t0, ax);
        d[1] = dot3(t1, ax);
        d[2] = dot3(t2, ax);
        tmin = d[0];
        tmax = d[0];
        for (int k = 1; k < 3; k++)
        begin
            if (d[k] < tmin) tmin = d[k];
            if (d[k] > tmax) tmax = d[k];
        end
        bmin = 0;
        bmax = 0;
        for (int k = 0; k < 3; k++)
        begin
            p = ax[k] * lo[k];
            q = ax[k] * hi[k];
            bmin += (p < q) ? p : q;
            bmax += (p < q) ? q : p;
        end
        return (bmax < tmin) || (tmax < bmin);
    endfunction

    function automatic bit box_tri_overlap(logic [WORD_BITS-1:0] bmn, bmx, va, vb, vc);
        vec_t lo, hi, t [3], ax, e, u;
        bit sep;
        lo = unpack_word(bmn);
        hi = unpack_word(bmx);
        t[0] = unpack_word(va);
        t[1] = unpack_word(vb);
        t[2] = unpack_word(vc);
        sep = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            ax = '{0, 0, 0};
            ax[j] = 1;
            sep |= axis_separates(ax, t[0], t[1], t[2], lo, hi);
        end
        for (int k = 0; k < 3; k++)
        begin
            e[k] = t[1][k] - t[0][k];
            u[k] = t[2][k] - t[0][k];
        end
        sep |= axis_separates(cross3(e, u), t[0], t[1], t[2], lo, hi);
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                e[k] = t[i][k] - t[(i + 1) % 3][k];
            for (int j = 0; j < 3; j++)
            begin
                u = '{0, 0, 0};
                u[j] = 1;
                sep |= axis_separates(cross3(u, e), t[0], t[1], t[2], lo, hi);
            end
        end
        return !sep;
    endfunction

    function automatic logic [WORD_BITS-1:0] pack3(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        return WORD_BITS'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Send one beat; sender may idle between bursts
    task automatic send_test(logic [WORD_BITS-1:0] bmn, bmx, va, vb, vc);
        int gap;
        @(negedge clk);
        in_ch.valid    = 1'b1;
        in_ch.box_min  = bmn;
        in_ch.box_max  = bmx;
        in_ch.vertex_a = va;
        in_ch.vertex_b = vb;
        in_ch.vertex_c = vc;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_overlaps.push_back(box_tri_overlap(bmn, bmx, va, vb, vc));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic hold_off_valid();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Extreme coordinates: full range box, corner values
    task automatic test_extremes();
        send_test(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
                  pack3(0, 0, 0), pack3(100, 0, 0), pack3(0, 100, 0));
        send_test(pack3(32767, 32767, 32767), pack3(32767, 32767, 32767),
                  pack3(-32768, -32768, -32768), pack3(32767, -32768, 32767),
                  pack3(-32768, 32767, 32767));
        send_test(pack3(-32768, -32768, -32768), pack3(-32768, -32768, -32768),
                  pack3(32767, 32767, 32767), pack3(-32768, 32767, -32768),
                  pack3(32767, -32768, -32768));
        send_test(48'h0, 48'h0, 48'h0, 48'h0, 48'h0);
        send_test({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 48'h0, {48{1'b1}});
        send_test(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
                  pack3(-32768, 32767, -32768), pack3(32767, -32768, 32767),
                  pack3(32767, 32767, -32768));
    endtask

    // Triangle touching a box face, edge and corner; and just off
    task automatic test_touching();
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(256, 0, 0), pack3(512, 0, 0), pack3(512, 256, 0));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(257, 0, 0), pack3(512, 0, 0), pack3(512, 256, 0));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(512, 0, 0), pack3(0, 512, 0), pack3(0, 0, 512));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(768, 0, 0), pack3(0, 768, 0), pack3(0, 0, 768));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(769, 0, 0), pack3(0, 769, 0), pack3(0, 0, 769));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(256, 256, 256), pack3(400, 300, 500), pack3(300, 600, 256));
    endtask

    // Degenerate triangles give a zero normal
    task automatic test_degenerate();
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(100, 100, 100), pack3(100, 100, 100), pack3(100, 100, 100));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(300, 300, 300), pack3(300, 300, 300), pack3(300, 300, 300));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(-100, -100, -100), pack3(50, 50, 50), pack3(500, 500, 500));
        send_test(pack3(0, 0, 0), pack3(256, 256, 256),
                  pack3(-100, 300, 0), pack3(0, 400, 0), pack3(100, 500, 0));
    endtask

    // Box corners given in reverse order
    task automatic test_swapped_corners();
        send_test(pack3(256, 256, 256), pack3(0, 0, 0),
                  pack3(100, 100, 100), pack3(300, 100, 100), pack3(100, 300, 100));
        send_test(pack3(256, 0, 256), pack3(0, 256, 0),
                  pack3(-10, -10, -10), pack3(-20, -5, -30), pack3(-5, -50, -1));
        send_test(pack3(-256, 512, -256), pack3(256, -512, 256),
                  pack3(250, 500, 250), pack3(600, 600, 600), pack3(250, 900, 0));
    endtask

    function automatic logic [WORD_BITS-1:0] near_point(int cx, cy, cz, int span);
        return pack3(cx + $urandom_range(0, 2 * span) - span,
                     cy + $urandom_range(0, 2 * span) - span,
                     cz + $urandom_range(0, 2 * span) - span);
    endfunction

    // Mostly nearby box/triangle pairs, some fully random words
    task automatic test_random(int count);
        int cx, cy, cz, span, hs;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_test(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
            else
            begin
                span = ($urandom_range(0, 7) == 0) ? 16000 : $urandom_range(4, 600);
                cx = $urandom_range(0, 65535) - 32768;
                cy = $urandom_range(0, 65535) - 32768;
                cz = $urandom_range(0, 65535) - 32768;
                hs = $urandom_range(0, span);
                send_test(pack3(cx - hs, cy - hs, cz - hs), pack3(cx + hs, cy + hs, cz + hs),
                          near_point(cx, cy, cz, 2 * span), near_point(cx, cy, cz, 2 * span),
                          near_point(cx, cy, cz, 2 * span));
            end
        end
    endtask

    task automatic test_drain_pause();
        hold_off_valid();
        wait (expected_overlaps.size() == 0);
        test_random(20);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_overlaps.size() == 0)
                report_mismatch("result beat with nothing expected");
            else if (out_ch.overlaps !== expected_overlaps[0])
            begin
                report_mismatch($sformatf("overlaps got %b want %b",
                                          out_ch.overlaps, expected_overlaps[0]));
                void'(expected_overlaps.pop_front());
            end
            else
                void'(expected_overlaps.pop_front());
        end
    end

    // Receiver stall pattern: phases of always-ready, random, long stalls
    initial
    begin
        int phase;
        out_ch.ready = 1'b0;
        forever
        begin
            phase = $urandom_range(0, 2);
            repeat ($urandom_range(20, 80))
            begin
                @(negedge clk);
                case (phase)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = 1'($urandom_range(0, 1));
                    default: out_ch.ready = ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (expected_overlaps.size() == 0 && !in_ch.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        fail_count     = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.box_min  = '0;
        in_ch.box_max  = '0;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        in_ch.vertex_c = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_touching();
        test_degenerate();
        test_swapped_corners();
        test_random(340);
        test_drain_pause();
        test_random(340);
        hold_off_valid();

        wait_cycles = 0;
        while (expected_overlaps.size() != 0 && wait_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_overlaps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
